// File: hw/rtl/assert_macros.svh
// assertion macros used by the formatter top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/itoa_pkg.sv
// shared types, constants and a function of the integer to ascii formatter
package itoa_pkg;

    localparam int VALUE_W    = 32;
    localparam int DIGIT_W    = 4;
    localparam int DEC_DIGITS = 10;
    localparam int HEX_DIGITS = VALUE_W / DIGIT_W;
    localparam int BCD_W      = DEC_DIGITS * DIGIT_W;
    localparam int CNT_W      = 4;
    localparam int SHIFT_W    = 6;

    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_MINUS   = 8'h2d;

    localparam logic FUNC_DEC = 1'b0;
    localparam logic FUNC_HEX = 1'b1;

    // load request from the controller into the character serializer
    typedef struct packed {
        logic              valid;
        logic [BCD_W-1:0]  digits;
        logic [CNT_W-1:0]  ndig;
        logic              neg;
    } emit_load_t;

    // status of the binary to bcd converter
    typedef struct packed {
        logic busy;
        logic done;
    } dabble_stat_t;

    // ascii code of one digit, decimal or hex
    function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [7:0] c;
        if (d < 4'd10)
            c = CHAR_ZERO + {4'd0, d};
        else
            c = CHAR_LOWER_A + {4'd0, d} - 8'd10;
        return c;
    endfunction

endpackage

// File: hw/rtl/itoa_dabble.sv
// bit-serial binary to bcd converter, one magnitude bit per cycle
module itoa_dabble (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [itoa_pkg::VALUE_W-1:0] mag,
    output itoa_pkg::dabble_stat_t       stat,
    output logic [itoa_pkg::BCD_W-1:0]   bcd
);
    import itoa_pkg::*;

    logic [VALUE_W-1:0] sh_reg, sh_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [SHIFT_W-1:0] cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [BCD_W-1:0]   adj;

    // add three to every digit of five or more
    always_comb
    begin
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= 4'd5)
                adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + 4'd3;
            else
                adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
        end
    end

    // shift sequencing
    always_comb
    begin
        sh_next   = sh_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            sh_next   = mag;
            bcd_next  = '0;
            cnt_next  = SHIFT_W'(VALUE_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next = {adj[BCD_W-2:0], sh_reg[VALUE_W-1]};
            sh_next  = {sh_reg[VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == SHIFT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // data registers
    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        bcd_reg <= bcd_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign bcd       = bcd_reg;

endmodule

// File: hw/rtl/itoa_emit.sv
// character serializer: skips leading zeros, emits sign and digits
module itoa_emit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  itoa_pkg::emit_load_t load,
    output logic                 busy,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           ch,
    output logic                 last
);
    import itoa_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SKIP  = 2'd1;
    localparam logic [1:0] ST_SIGN  = 2'd2;
    localparam logic [1:0] ST_DIGIT = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [BCD_W-1:0] dig_reg, dig_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic             neg_reg, neg_next;
    logic             valid_reg, valid_next;
    logic [7:0]       ch_reg, ch_next;
    logic             last_reg, last_next;
    logic [DIGIT_W-1:0] top;
    logic             slot;

    assign top  = dig_reg[BCD_W-1 -: DIGIT_W];
    assign slot = !valid_reg || out_ready;

    // serializer state machine
    always_comb
    begin
        state_next = state_reg;
        dig_next   = dig_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        valid_next = valid_reg;
        ch_next    = ch_reg;
        last_next  = last_reg;
        if (valid_reg && out_ready)
            valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (load.valid)
                begin
                    dig_next   = load.digits;
                    rem_next   = load.ndig;
                    neg_next   = load.neg;
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (top == '0 && rem_reg != CNT_W'(1))
                begin
                    dig_next = {dig_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    rem_next = rem_reg - 1'b1;
                end
                else if (neg_reg)
                    state_next = ST_SIGN;
                else
                    state_next = ST_DIGIT;
            end
            ST_SIGN:
            begin
                if (slot)
                begin
                    valid_next = 1'b1;
                    ch_next    = CHAR_MINUS;
                    last_next  = 1'b0;
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (slot)
                begin
                    valid_next = 1'b1;
                    ch_next    = digit_char(top);
                    last_next  = (rem_reg == CNT_W'(1));
                    dig_next   = {dig_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    rem_next   = rem_reg - 1'b1;
                    if (rem_reg == CNT_W'(1))
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            rem_reg   <= rem_next;
        end
    end

    // data registers
    always_ff @(posedge clk)
    begin
        dig_reg  <= dig_next;
        neg_reg  <= neg_next;
        ch_reg   <= ch_next;
        last_reg <= last_next;
    end

    assign busy      = (state_reg != ST_IDLE) || valid_reg;
    assign out_valid = valid_reg;
    assign ch        = ch_reg;
    assign last      = last_reg;

endmodule

// File: hw/rtl/integer_to_ascii_formatter.sv
// top level of the integer to ascii formatter
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  input   | in_valid, in_ready, value, func  | in
//  output  | out_valid, out_ready, ch, last   | out
//
// one value at a time; in_ready stays low until its last character is taken
// decimal: the bcd converter shifts in every magnitude bit, then loads the serializer,
// which skips up to 9 leading zeros; hex: the nibbles load the serializer at the transfer
// and up to 7 leading zeros are skipped; the characters then go out back to back
// a stalled output holds the serializer; reset clears all control state
module integer_to_ascii_formatter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [itoa_pkg::VALUE_W-1:0] value,
    input  logic                         func,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [7:0]                   ch,
    output logic                         last
);
    import itoa_pkg::*;
    `include "assert_macros.svh"

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_CONV = 1'b1;

    logic               state_reg, state_next;
    logic               neg_reg, neg_next;
    logic               in_xfer;
    logic               start;
    logic [VALUE_W-1:0] mag;
    dabble_stat_t       dstat;
    logic [BCD_W-1:0]   bcd;
    emit_load_t         load;
    logic               emit_busy;

    assign in_ready = (state_reg == ST_IDLE) && !dstat.busy && !emit_busy;
    assign in_xfer  = in_valid && in_ready;
    assign start    = in_xfer && (func == FUNC_DEC);
    assign mag      = value[VALUE_W-1] ? VALUE_W'(~value + 1'b1) : value;

    // controller: route decimal through the converter, hex straight out
    always_comb
    begin
        state_next  = state_reg;
        neg_next    = neg_reg;
        load.valid  = 1'b0;
        load.digits = {value, {(BCD_W-VALUE_W){1'b0}}};
        load.ndig   = CNT_W'(HEX_DIGITS);
        load.neg    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (func == FUNC_HEX)
                        load.valid = 1'b1;
                    else
                    begin
                        neg_next   = value[VALUE_W-1];
                        state_next = ST_CONV;
                    end
                end
            end
            ST_CONV:
            begin
                load.digits = bcd;
                load.ndig   = CNT_W'(DEC_DIGITS);
                load.neg    = neg_reg;
                if (dstat.done)
                begin
                    load.valid = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // sign of the value in conversion
    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
    end

    itoa_dabble u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mag   (mag),
        .stat  (dstat),
        .bcd   (bcd)
    );

    itoa_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .busy      (emit_busy),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ch        (ch),
        .last      (last)
    );

    // checks
    `ASSERT_IMPL(a_ready_no_out, clk, rst_n, in_ready, !out_valid)
    `ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready)
    `ASSERT_IMPL(a_done_in_conv, clk, rst_n, dstat.done, state_reg == ST_CONV)
    `ASSERT_NEXT(a_text_continues, clk, rst_n, out_valid && out_ready && !last, out_valid)

endmodule
